// ===== rtl/ahsd_pkg.sv =====
package ahsd_pkg;

  localparam int unsigned WORDS      = 20;
  localparam int unsigned STORE_D    = 21;
  localparam int unsigned LAST_POS   = 23;
  localparam int unsigned MAX_COUNT  = 2000000;
  localparam int unsigned MAX_FILES  = 1000000;
  localparam int unsigned MIN_OFFSET = 92;

  localparam logic [31:0] K_SALT  = 32'hA3C59AC3;
  localparam logic [31:0] K_MUL1  = 32'h85EBCA6B;
  localparam logic [31:0] K_MUL2  = 32'hC2B2AE35;
  localparam logic [31:0] K_ADD1  = 32'h165667B1;
  localparam logic [31:0] K_SUB1  = 32'h7A143595;
  localparam logic [31:0] K_GOLD  = 32'h9E3779B9;
  localparam logic [31:0] K_CSUB  = 32'h61C88647;
  localparam logic [31:0] K_CADD  = 32'h3C6EF372;
  localparam logic [31:0] K_XMIX  = 32'h1B873593;
  localparam logic [31:0] K_IDXM  = 32'h27D4EB2D;
  localparam logic [31:0] K_IDXA  = 32'h7F4A7C15;
  localparam logic [31:0] K_SUB0  = 32'hE9A9984F;

  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[31:0];
  endfunction

  function automatic logic [31:0] odd_inverse(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      r = mul_lo(r, 32'd2 - mul_lo(v, r));
    end
    return r;
  endfunction

  localparam logic [31:0] INV_MUL1 = odd_inverse(K_MUL1);
  localparam logic [31:0] INV_MUL2 = odd_inverse(K_MUL2);

  // tail byte constants, indexed by byte number in the tail
  function automatic logic [31:0] idx_mix(input logic [1:0] t);
    case (t)
      2'd0:    return mul_lo(32'd80, K_IDXM) + K_IDXA;
      2'd1:    return mul_lo(32'd81, K_IDXM) + K_IDXA;
      2'd2:    return mul_lo(32'd82, K_IDXM) + K_IDXA;
      default: return mul_lo(32'd83, K_IDXM) + K_IDXA;
    endcase
  endfunction

  function automatic logic [31:0] tail_side(input logic [1:0] t);
    case (t)
      2'd0:    return mul_lo(32'd80, K_GOLD);
      2'd1:    return mul_lo(32'd81, K_GOLD);
      2'd2:    return mul_lo(32'd82, K_GOLD);
      default: return mul_lo(32'd83, K_GOLD);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

endpackage

// ===== rtl/archive_header_stream_decoder.sv =====
// Decodes one 84-byte catalog header (20 cipher words then 4 tail bytes) for one trial
// count, giving one plain word or byte per input word. All multiplies go through a single
// registered 32x32 multiplier driven by a small sequencer, and the block takes one word at
// a time: a cipher word takes two multiplier passes before the next ready, a tail byte one
// pass, a start word first runs the key inversion, and the final tail byte then runs the
// structure checks, done one check per cycle. A finished result waits in the output
// register while the next word is taken. archive_bytes may be written at any idle time
// through the cfg channel.
module archive_header_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cipher[31:0], trial_count[52:32], zero pad
  input  logic        in_tuser,   // start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // plain[31:0], position[36:32], header_ok[37],
                                  // recovered_key[69:38], zero pad
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [33:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_K1, S_K2, S_DEC, S_M1, S_M2, S_TAIL, S_CHK, S_DONE
  } state_t;

  state_t      state_r;
  logic [33:0] lim_r;
  logic [31:0] cin_r;
  logic        start_r;
  logic [20:0] cnt_in_r;
  logic [31:0] rk_r, cw_r, chain_r, side_r, prior_r, dkey_r, plain_r;
  logic [4:0]  pos_r;
  logic [20:0] held_r;
  logic [31:0] hdr_r [0:ahsd_pkg::STORE_D-1];
  logic        ok_r;
  logic [3:0]  step_r;
  logic        out_valid_r, out_last_r, out_ok_r;
  logic [31:0] out_plain_r, out_key_r;
  logic [4:0]  out_pos_r;

  logic [31:0] mul_a, mul_b, mul_p;

  ahsd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  // combinational pieces of each step
  logic [31:0] mk, k1m, mm1, mm2;
  logic [31:0] ev_rk, ev_side, ev_chain, ev_prior, od_x;
  logic [31:0] tl_side, tl_chain, tl_m, tl_m2;
  logic [4:0]  tl_rot;
  logic [1:0]  tb;
  logic        is_tail, is_even;

  assign tb      = pos_r[1:0];
  assign is_tail = (pos_r >= 5'(ahsd_pkg::WORDS));
  assign is_even = !pos_r[0];

  always_comb begin
    mk  = (cin_r ^ 32'(cnt_in_r));
    mk  = mk ^ (mk >> 13) ^ (mk >> 26);
    k1m = mul_p ^ (mul_p >> 16);
    k1m = ahsd_pkg::rotl(k1m, 5'd25);
    mm1 = ahsd_pkg::rotl(mul_p, 5'd7);
    mm1 = mm1 ^ (mm1 >> 16);
    mm2 = mul_p ^ (mul_p >> 13);

    ev_rk   = rk_r ^ side_r;
    ev_side = side_r;
    if (chain_r != 32'd0) begin
      ev_side = side_r + ahsd_pkg::K_MUL2;
      ev_rk   = ahsd_pkg::rotl(ev_rk ^ chain_r, 5'd11) + ahsd_pkg::K_ADD1;
    end
    ev_chain = cin_r ^ prior_r;
    ev_prior = prior_r;
    if (ev_rk != 32'd0) begin
      ev_chain = ahsd_pkg::rotl(ev_chain ^ ev_rk, 5'd7) - ahsd_pkg::K_SUB1;
      ev_prior = prior_r + ahsd_pkg::K_GOLD;
    end
    od_x = (cw_r - ahsd_pkg::K_CSUB) ^ chain_r ^ ahsd_pkg::K_XMIX;

    tl_side  = side_r ^ rk_r;
    tl_rot   = (tb == 2'd0) ? 5'd11 : {1'b0, chain_r[3:0] ^ rk_r[3:0]};
    tl_chain = ahsd_pkg::rotl(chain_r ^ tl_side, tl_rot)
             - ((tb == 2'd0) ? ahsd_pkg::K_SUB0 : ahsd_pkg::K_SUB1);
    tl_m     = tl_chain ^ ahsd_pkg::idx_mix(tb);
    tl_m2    = tl_m ^ (tl_m >> 15);
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = ahsd_pkg::K_MUL1;
    case (state_r)
      S_PREP: begin
        mul_a = mk;
        mul_b = ahsd_pkg::INV_MUL2;
      end
      S_K1: begin
        mul_a = k1m;
        mul_b = ahsd_pkg::INV_MUL1;
      end
      S_DEC: begin
        if (is_tail)      mul_a = tl_m2;
        else if (is_even) mul_a = ev_rk ^ cw_r ^ ahsd_pkg::K_SALT;
        else              mul_a = od_x;
      end
      S_M1: begin
        mul_a = mm1;
        mul_b = ahsd_pkg::K_MUL2;
      end
      default: ;
    endcase
  end

  // structure checks, one check per step
  logic        chk;
  logic [35:0] w0x12, w1x12;
  logic [32:0] s58, s811, s1114, s1417, s1517;

  always_comb begin
    w0x12 = 36'({hdr_r[0], 3'b0}) + 36'({hdr_r[0], 2'b0});
    w1x12 = 36'({hdr_r[1], 3'b0}) + 36'({hdr_r[1], 2'b0});
    s58   = 33'(hdr_r[5])  + 33'(hdr_r[3]);
    s811  = 33'(hdr_r[8])  + 33'(hdr_r[6]);
    s1114 = 33'(hdr_r[11]) + 33'(hdr_r[9]);
    s1417 = 33'(hdr_r[14]) + 33'(hdr_r[12]);
    s1517 = 33'(hdr_r[17]) + 33'(hdr_r[15]);
    case (step_r)
      4'd0: chk = (hdr_r[0] == 32'(held_r)) && (hdr_r[0] <= ahsd_pkg::MAX_COUNT)
                  && (hdr_r[1] <= ahsd_pkg::MAX_FILES);
      4'd1: chk = (36'(hdr_r[3]) == w1x12);
      4'd2: chk = (36'(hdr_r[6]) == w0x12);
      4'd3: chk = (s58 == 33'(hdr_r[8]));
      4'd4: chk = (s811 == 33'(hdr_r[11]));
      4'd5: chk = (s1114 == 33'(hdr_r[14]));
      4'd6: chk = (s1417 == 33'(hdr_r[17]));
      4'd7: chk = (hdr_r[5] >= ahsd_pkg::MIN_OFFSET) && (34'(s1517) <= lim_r);
      4'd8: chk = (34'(hdr_r[20]) <= lim_r);
      default: chk = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lim_r       <= 34'h200000000;
      rk_r        <= '0;
      cw_r        <= '0;
      chain_r     <= '0;
      side_r      <= '0;
      prior_r     <= '0;
      pos_r       <= '0;
      held_r      <= '0;
      dkey_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) lim_r <= cfg_data;
      // a word loaded in S_DONE takes over the register in the same cycle
      if (out_valid_r && out_tready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cin_r    <= in_tdata[31:0];
            cnt_in_r <= in_tdata[52:32];
            start_r  <= in_tuser;
            state_r  <= S_PREP;
          end
        end
        S_PREP: begin
          if (start_r) begin
            held_r  <= cnt_in_r;
            cw_r    <= '0;
            chain_r <= '0;
            side_r  <= '0;
            prior_r <= '0;
            pos_r   <= '0;
            state_r <= S_K1;
          end else begin
            state_r <= S_DEC;
          end
        end
        S_K1: state_r <= S_K2;
        S_K2: begin
          dkey_r  <= mul_p ^ ahsd_pkg::K_SALT;
          rk_r    <= mul_p ^ ahsd_pkg::K_SALT;
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (is_tail) begin
            chain_r <= tl_chain;
            rk_r    <= {24'd0, cin_r[7:0]};
            side_r  <= ahsd_pkg::tail_side(tb);
            state_r <= S_TAIL;
          end else if (is_even) begin
            rk_r    <= ev_rk;
            side_r  <= ev_side;
            chain_r <= ev_chain;
            prior_r <= ev_prior;
            state_r <= S_M1;
          end else begin
            cw_r    <= cw_r + ahsd_pkg::K_CADD;
            rk_r    <= cin_r;
            state_r <= S_M1;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          plain_r      <= cin_r ^ mm2;
          hdr_r[pos_r] <= cin_r ^ mm2;
          ok_r         <= 1'b0;
          state_r      <= S_DONE;
        end
        S_TAIL: begin
          plain_r <= {24'd0, cin_r[7:0] ^ mul_p[7:0] ^ mul_p[20:13]};
          case (tb)
            2'd0: hdr_r[20][7:0]   <= cin_r[7:0] ^ mul_p[7:0] ^ mul_p[20:13];
            2'd1: hdr_r[20][15:8]  <= cin_r[7:0] ^ mul_p[7:0] ^ mul_p[20:13];
            2'd2: hdr_r[20][23:16] <= cin_r[7:0] ^ mul_p[7:0] ^ mul_p[20:13];
            default: hdr_r[20][31:24] <= cin_r[7:0] ^ mul_p[7:0] ^ mul_p[20:13];
          endcase
          ok_r    <= (tb == 2'd3);
          step_r  <= '0;
          state_r <= (tb == 2'd3) ? S_CHK : S_DONE;
        end
        S_CHK: begin
          ok_r   <= ok_r & chk;
          step_r <= step_r + 4'd1;
          if (step_r == 4'd8) state_r <= S_DONE;
        end
        S_DONE: begin
          // hand the word to the output register once it is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_plain_r <= plain_r;
            out_pos_r   <= pos_r;
            out_last_r  <= (pos_r == 5'(ahsd_pkg::LAST_POS));
            out_ok_r    <= ok_r;
            out_key_r   <= dkey_r;
            pos_r       <= (pos_r >= 5'(ahsd_pkg::LAST_POS)) ? 5'd0 : pos_r + 5'd1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_key_r, out_ok_r, out_pos_r, out_plain_r};

endmodule

// ===== rtl/ahsd_mul.sv =====
module ahsd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p_r
);

  logic [63:0] full;

  assign full = 64'(a) * 64'(b);

  always_ff @(posedge clk) begin
    p_r <= full[31:0];
  end

endmodule
